>>> design/spmv_pkg.sv
// Shared types and constants of the CSR sparse matrix-vector multiply core.
package spmv_pkg;

    localparam int FUNC_W      = 2;
    localparam int SLOT_W      = 8;
    localparam int PTR_W       = 9;
    localparam int COL_W       = 4;
    localparam int VAL_W       = 16;
    localparam int ROW_W       = 4;
    localparam int SUM_W       = 48;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int ROW_COUNT_W = 5;

    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 5'd4;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_PTR = 2'd0,
        FUNC_LOAD_NZ  = 2'd1,
        FUNC_LOAD_VEC = 2'd2,
        FUNC_COMPUTE  = 2'd3
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [SLOT_W-1:0]       slot;
        logic [PTR_W-1:0]        row_start;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] data_value;
    } t_request;

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_result;

    // Controls from the sequencer into the multiply-accumulate pipe.
    typedef struct packed {
        logic clear;     // zero the accumulator for a new row
        logic nz_valid;  // nonzero read data is valid this cycle
        logic in_range;  // its column addresses a real vector element
    } t_mac_ctl;

endpackage

>>> design/csr_sparse_matrix_vector_multiply_core.sv
// Load requests (row pointer, nonzero, vector element) give no result.
// Compute: fetch row pointer 0, then per row the end pointer, one nonzero read per cycle,
//   a stop when the walk ends, and a drain of the multiply-accumulate pipe before the result.
// Results come one per row, each on o_result for one cycle; the receiver cannot stall.
// busy is high from accept of a compute with a nonzero row count until the last row's result is shown.
// Synchronous active-low reset clears control and sets the row count to 4; stores stay unset.
module csr_sparse_matrix_vector_multiply_core import spmv_pkg::*; #(
    parameter int MAX_ROWS      = 16,
    parameter int MAX_NONZEROS  = 256,
    parameter int VECTOR_LENGTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_request               i_request,
    input  logic                   i_cfg_we,
    input  logic [ROW_COUNT_W-1:0] i_cfg_wdata,
    output logic                   o_result_valid,
    output t_result                o_result
);

    // Row width fits 0..MAX_ROWS: the row count and the row pointer store address.
    localparam int RW     = $clog2(MAX_ROWS + 1);
    localparam int RW1    = RW + 1;
    localparam int NZ_AW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int VEC_AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam int NZ_W   = COL_W + VAL_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,   // row pointer 0 arrives
        S_END   = 5'b00100,   // end pointer of the current row arrives
        S_WALK  = 5'b01000,   // one nonzero read issued per cycle
        S_DRAIN = 5'b10000    // wait for the pipe, then emit the row
    } t_state;

    t_state                 r_state, n_state;
    logic [RW-1:0]          r_row, n_row;
    logic [RW-1:0]          r_nrows, n_nrows;
    logic [PTR_W-1:0]       r_k, n_k;
    logic [PTR_W-1:0]       r_end, n_end;
    logic                   r_v1;
    logic [ROW_COUNT_W-1:0] r_row_count, n_row_count;
    logic                   r_out_valid, n_out_valid;
    t_result                r_out, n_out;

    logic                  accept;
    logic                  walk_go;
    logic                  last_row;
    logic [RW-1:0]         rows_eff;

    // store ports
    logic                  rp_we, rp_re;
    logic [RW-1:0]         rp_raddr;
    logic [PTR_W-1:0]      rp_rdata;
    logic                  nz_we;
    logic [NZ_W-1:0]       nz_rdata;
    logic [COL_W-1:0]      nz_col;
    logic signed [VAL_W-1:0] nz_val;
    logic                  vec_we, vec_re;
    logic                  col_in_range;
    logic signed [VAL_W-1:0] vec_rdata;

    t_mac_ctl              mac_ctl;
    logic signed [SUM_W-1:0] mac_sum;
    logic                  mac_pending;

    assign busy   = (r_state != S_IDLE);
    assign accept = start & ~busy;

    // Loads write only while idle; compute reads only while busy or at its own
    // accept, so the stores never see a read and a write to the same entry together.
    assign rp_we  = accept && (i_request.func == FUNC_LOAD_PTR)
                    && (32'(i_request.slot) < MAX_ROWS + 1);
    assign nz_we  = accept && (i_request.func == FUNC_LOAD_NZ)
                    && (32'(i_request.slot) < MAX_NONZEROS);
    assign vec_we = accept && (i_request.func == FUNC_LOAD_VEC)
                    && (32'(i_request.slot) < VECTOR_LENGTH);

    // Rows past MAX_ROWS are dropped.
    assign rows_eff = (32'(r_row_count) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(r_row_count);

    // Walk stops at the end pointer or at the top of the nonzero store.
    assign walk_go  = (r_state == S_WALK) && (r_k < r_end)
                      && (32'(r_k) < MAX_NONZEROS);
    assign last_row = (RW1'(r_row) + RW1'(1)) == RW1'(r_nrows);

    assign nz_col       = nz_rdata[NZ_W-1:VAL_W];
    assign nz_val       = nz_rdata[VAL_W-1:0];
    assign col_in_range = (32'(nz_col) < VECTOR_LENGTH);
    assign vec_re       = r_v1 & col_in_range;

    assign mac_ctl.clear    = (r_state == S_END);
    assign mac_ctl.nz_valid = r_v1;
    assign mac_ctl.in_range = col_in_range;

    spmv_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_ROWS + 1)
    ) u_rp_ram (
        .i_clk   (i_clk),
        .i_we    (rp_we),
        .i_waddr (RW'(i_request.slot)),
        .i_wdata (i_request.row_start),
        .i_re    (rp_re),
        .i_raddr (rp_raddr),
        .o_rdata (rp_rdata)
    );

    // column index and value share one entry
    spmv_ram #(
        .WIDTH (NZ_W),
        .DEPTH (MAX_NONZEROS)
    ) u_nz_ram (
        .i_clk   (i_clk),
        .i_we    (nz_we),
        .i_waddr (NZ_AW'(i_request.slot)),
        .i_wdata ({i_request.column, i_request.data_value}),
        .i_re    (walk_go),
        .i_raddr (NZ_AW'(r_k)),
        .o_rdata (nz_rdata)
    );

    spmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VECTOR_LENGTH)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (VEC_AW'(i_request.slot)),
        .i_wdata (i_request.data_value),
        .i_re    (vec_re),
        .i_raddr (VEC_AW'(nz_col)),
        .o_rdata (vec_rdata)
    );

    spmv_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_value   (nz_val),
        .i_vec     (vec_rdata),
        .o_sum     (mac_sum),
        .o_pending (mac_pending)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_nrows     = r_nrows;
        n_k         = r_k;
        n_end       = r_end;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_row_count = i_cfg_we ? i_cfg_wdata : r_row_count;
        rp_re       = 1'b0;
        rp_raddr    = '0;
        unique case (r_state)
            S_IDLE: begin
                // zero rows: compute gives nothing and stays idle
                if (accept && (i_request.func == FUNC_COMPUTE) && (rows_eff != '0)) begin
                    n_nrows  = rows_eff;
                    n_row    = '0;
                    rp_re    = 1'b1;
                    rp_raddr = '0;
                    n_state  = S_START;
                end
            end
            S_START: begin
                n_k      = rp_rdata;
                rp_re    = 1'b1;
                rp_raddr = r_row + RW'(1);
                n_state  = S_END;
            end
            S_END: begin
                n_end   = rp_rdata;
                n_state = S_WALK;
            end
            S_WALK: begin
                // empty or inverted row falls straight through with sum zero
                if (walk_go) begin
                    n_k = r_k + PTR_W'(1);
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !mac_pending) begin
                    n_out_valid = 1'b1;
                    n_out.row   = ROW_W'(r_row);
                    n_out.sum   = mac_sum;
                    n_out.last  = last_row;
                    if (last_row) begin
                        n_state = S_IDLE;
                    end else begin
                        // this row's end pointer starts the next row
                        n_row    = r_row + RW'(1);
                        n_k      = r_end;
                        rp_re    = 1'b1;
                        rp_raddr = RW'(RW1'(r_row) + RW1'(2));
                        n_state  = S_END;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_count <= ROW_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_v1        <= walk_go;
            r_out_valid <= n_out_valid;
            r_row_count <= n_row_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_nrows <= n_nrows;
        r_k     <= n_k;
        r_end   <= n_end;
        r_out   <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

>>> design/spmv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module spmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/spmv_mac.sv
// Multiply-accumulate pipe: value x vector product, then saturating Q32.16 sum.
module spmv_mac import spmv_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctl                i_ctl,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic signed [VAL_W-1:0] i_vec,
    output logic signed [SUM_W-1:0] o_sum,
    output logic                    o_pending
);

    logic                     r_v2;
    logic                     r_v3;
    logic                     r_inr2;
    logic signed [VAL_W-1:0]  r_val2;
    logic signed [PROD_W-1:0] r_prod3;
    logic signed [SUM_W-1:0]  r_acc;

    logic signed [PROD_W-1:0] n_prod3;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  n_acc;

    always_comb begin
        if (r_inr2) begin
            n_prod3 = r_val2 * i_vec;
        end else begin
            n_prod3 = '0;
        end
    end

    // one extra bit catches overflow past either rail
    always_comb begin
        sum_wide = (SUM_W+1)'(r_acc) + (SUM_W+1)'(r_prod3);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            n_acc = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_acc = sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.nz_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val2  <= i_value;
        r_inr2  <= i_ctl.in_range;
        r_prod3 <= n_prod3;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= n_acc;
        end
    end

    assign o_sum     = r_acc;
    assign o_pending = r_v2 | r_v3;

endmodule

>>> bench/tb_csr_sparse_matrix_vector_multiply_core.sv
// Self-checking bench for the CSR sparse matrix-vector multiply core: driver, monitor, scoreboard.
module tb_csr_sparse_matrix_vector_multiply_core import spmv_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS       = 16;
    localparam int MAX_NONZEROS   = 256;
    localparam int VECTOR_LENGTH  = 16;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    // Worst stretch without any handshake is one long row or a settle pause;
    // this is several times that.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    // random loads and computes, ignored loads not counted
    localparam int RANDOM_ITEMS   = 220;

    // ------------------------------------------------------------------
    // DUT signals, all inputs at known values from time zero
    // ------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    t_request               i_request   = '0;
    logic                   i_cfg_we    = 1'b0;
    logic [ROW_COUNT_W-1:0] i_cfg_wdata = '0;
    logic                   o_result_valid;
    t_result                o_result;

    csr_sparse_matrix_vector_multiply_core #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_NONZEROS  (MAX_NONZEROS),
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_request pending_req[$];     // requests waiting for the driver
    t_result  expected_rows[$];   // row results still owed by the core

    bit req_taken     = 1'b0;     // request handshake happened at last rising edge
    int idle_cycles   = 0;        // cycles with no handshake of any kind
    int accepted      = 0;
    int computes_seen = 0;
    int rows_checked  = 0;
    int errors        = 0;
    int settings_used = 0;

    // Predictor copy of the core's register and stores
    logic [ROW_COUNT_W-1:0]  rows_cfg;
    logic [PTR_W-1:0]        rp_mem  [MAX_ROWS+1];
    logic [COL_W-1:0]        col_mem [MAX_NONZEROS];
    logic signed [VAL_W-1:0] val_mem [MAX_NONZEROS];
    logic signed [VAL_W-1:0] vec_mem [VECTOR_LENGTH];

    // Stimulus-side shadow: which entries are written, so a compute never
    // reads a store entry that holds no defined value.
    int gen_cfg = ROW_COUNT_RESET;
    int gen_rp     [MAX_ROWS+1];
    bit gen_rp_ok  [MAX_ROWS+1];
    int gen_col    [MAX_NONZEROS];
    bit gen_nz_ok  [MAX_NONZEROS];
    bit gen_vec_ok [VECTOR_LENGTH];
    int gen_items = 0;            // items that the core does not ignore

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturating Q32.16 dot product of one CSR row.
    function automatic logic signed [SUM_W-1:0] row_dot(input int r);
        longint acc;
        longint prod;
        longint x;
        int s;
        int e;
        int k;
        acc = 0;
        s = int'(rp_mem[r]);
        e = int'(rp_mem[r+1]);
        for (k = s; k < e && k < MAX_NONZEROS; k++) begin
            x = (int'(col_mem[k]) < VECTOR_LENGTH) ? longint'(vec_mem[col_mem[k]]) : 0;
            prod = longint'(val_mem[k]) * x;
            acc = acc + prod;
            if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
            if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
        end
        return acc[SUM_W-1:0];
    endfunction

    // Apply one accepted request to the predictor; computes queue their rows.
    task automatic apply_request(input t_request rq);
        t_result res;
        int nrows;
        int r;
        case (t_func'(rq.func))
            FUNC_LOAD_PTR: if (int'(rq.slot) < MAX_ROWS + 1) rp_mem[rq.slot] = rq.row_start;
            FUNC_LOAD_NZ: begin
                col_mem[rq.slot] = rq.column;
                val_mem[rq.slot] = rq.data_value;
            end
            FUNC_LOAD_VEC: if (int'(rq.slot) < VECTOR_LENGTH) vec_mem[rq.slot] = rq.data_value;
            FUNC_COMPUTE: begin
                computes_seen++;
                // register values above the row capacity clamp to it
                nrows = (int'(rows_cfg) > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
                for (r = 0; r < nrows; r++) begin
                    res.row  = r[ROW_W-1:0];
                    res.sum  = row_dot(r);
                    res.last = (r + 1 == nrows);
                    expected_rows.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge, checks rows, feeds predictor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        bit      progress;
        progress = 1'b0;
        if (!i_rst_n) begin
            rows_cfg = ROW_COUNT_RESET;
            req_taken <= 1'b0;
            idle_cycles = 0;
        end else begin
            // Results first: the core cannot be held off, every strobe counts.
            if (o_result_valid) begin
                progress = 1'b1;
                if (expected_rows.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected row result: expected none, ",
                              "actual row %0d sum %0d last %0b"},
                             $time, o_result.row, o_result.sum, o_result.last);
                end else begin
                    want = expected_rows.pop_front();
                    rows_checked++;
                    if (o_result.row !== want.row) begin
                        errors++;
                        $display("%0t: row index mismatch: expected %0d actual %0d",
                                 $time, want.row, o_result.row);
                    end
                    if (o_result.sum !== want.sum) begin
                        errors++;
                        $display("%0t: row %0d sum mismatch: expected %0d actual %0d",
                                 $time, want.row, want.sum, o_result.sum);
                    end
                    if (o_result.last !== want.last) begin
                        errors++;
                        $display("%0t: row %0d last flag mismatch: expected %0b actual %0b",
                                 $time, want.row, want.last, o_result.last);
                    end
                end
            end
            if (i_cfg_we) rows_cfg = i_cfg_wdata;
            if (start && !busy) begin
                progress = 1'b1;
                accepted++;
                apply_request(i_request);
            end
            req_taken <= start && !busy;
            idle_cycles = progress ? 0 : idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Driver: changes inputs at the falling edge, holds a request until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        bit steady;
        bit gap;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            // a long stretch with no gaps at all, random gaps elsewhere
            steady = (accepted >= 120 && accepted < 220);
            gap = !steady && ($urandom_range(0, 99) < 9);
            if (pending_req.size() != 0 && !gap) begin
                i_request <= pending_req.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Q8.8 value biased toward both extremes.
    function automatic logic [VAL_W-1:0] pick_q88();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 16'h7FFF;
        if (sel == 1) return 16'h8000;
        return VAL_W'($urandom);
    endfunction

    // Queue one request and track what it writes.
    task automatic push_req(input t_func f, input int slot, input int rs, input int col,
                            input logic [VAL_W-1:0] dv);
        t_request rq;
        bit       ignored;
        rq.func       = f;
        rq.slot       = slot[SLOT_W-1:0];
        rq.row_start  = rs[PTR_W-1:0];
        rq.column     = col[COL_W-1:0];
        rq.data_value = dv;
        ignored = 1'b0;
        case (f)
            FUNC_LOAD_PTR: begin
                if (slot < MAX_ROWS + 1) begin
                    gen_rp[slot] = rs;
                    gen_rp_ok[slot] = 1'b1;
                end else begin
                    ignored = 1'b1;
                end
            end
            FUNC_LOAD_NZ: begin
                gen_col[slot] = col;
                gen_nz_ok[slot] = 1'b1;
            end
            FUNC_LOAD_VEC: begin
                if (slot < VECTOR_LENGTH) gen_vec_ok[slot] = 1'b1;
                else ignored = 1'b1;
            end
            default: ;
        endcase
        if (!ignored) gen_items++;
        pending_req.push_back(rq);
    endtask

    // True when a compute under the current setting reads only written entries.
    function automatic bit reads_are_defined();
        int n;
        int r;
        int k;
        n = (gen_cfg > MAX_ROWS) ? MAX_ROWS : gen_cfg;
        for (r = 0; r < n; r++) begin
            if (!gen_rp_ok[r] || !gen_rp_ok[r+1]) return 1'b0;
            for (k = gen_rp[r]; k < gen_rp[r+1] && k < MAX_NONZEROS; k++) begin
                if (!gen_nz_ok[k] || !gen_vec_ok[gen_col[k]]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic push_compute();
        if (reads_are_defined())
            push_req(FUNC_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 256),
                     $urandom_range(0, 15), VAL_W'($urandom));
    endtask

    // Loads that the core ignores, or that rewrite safe entries.
    task automatic maybe_noise();
        int pick;
        if ($urandom_range(0, 5) != 0) return;
        pick = $urandom_range(0, 2);
        case (pick)
            0: push_req(FUNC_LOAD_PTR, $urandom_range(MAX_ROWS + 1, 255), $urandom_range(0, 256),
                        $urandom_range(0, 15), VAL_W'($urandom));
            1: push_req(FUNC_LOAD_NZ, $urandom_range(0, 255), $urandom_range(0, 256),
                        $urandom_range(0, 15), pick_q88());
            default: push_req(FUNC_LOAD_VEC,
                              ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(16, 255),
                              $urandom_range(0, 256), $urandom_range(0, 15), pick_q88());
        endcase
    endtask

    // Load a fresh CSR matrix of n rows: mostly short rows, some empty or inverted.
    task automatic build_matrix(input int n);
        int ptrs[MAX_ROWS+1];
        int cur;
        int nxt;
        int kind;
        int r;
        int k;
        cur = ($urandom_range(0, 3) == 0) ? $urandom_range(230, 256) : $urandom_range(0, 200);
        ptrs[0] = cur;
        for (r = 0; r < n; r++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) nxt = cur;
            else if (kind == 1 && cur > 0) nxt = cur - $urandom_range(1, (cur < 8) ? cur : 8);
            else nxt = cur + $urandom_range(1, 5);
            if (nxt > MAX_NONZEROS) nxt = MAX_NONZEROS;
            ptrs[r+1] = nxt;
            cur = nxt;
        end
        for (r = 0; r < n; r++) begin
            for (k = ptrs[r]; k < ptrs[r+1]; k++) begin
                maybe_noise();
                push_req(FUNC_LOAD_NZ, k, $urandom_range(0, 256), $urandom_range(0, 15),
                         pick_q88());
            end
        end
        for (r = 0; r <= n; r++) begin
            maybe_noise();
            push_req(FUNC_LOAD_PTR, r, ptrs[r], $urandom_range(0, 15), VAL_W'($urandom));
        end
    endtask

    // Small edits to the vector or to nonzero store entries before a recompute.
    task automatic tweak_operands();
        int count;
        int i;
        count = $urandom_range(1, 3);
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) != 0)
                push_req(FUNC_LOAD_VEC, $urandom_range(0, 15), $urandom_range(0, 256),
                         $urandom_range(0, 15), pick_q88());
            else
                push_req(FUNC_LOAD_NZ, $urandom_range(0, 255), $urandom_range(0, 256),
                         $urandom_range(0, 15), pick_q88());
        end
    endtask

    // Sender pause: wait for the queue, the core and every owed row, then settle.
    // Checked at the rising edge, where start and busy are stable.
    task automatic drain();
        while (pending_req.size() != 0 || start || busy || expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write, only while the core is idle.
    task automatic write_rows(input int value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[ROW_COUNT_W-1:0];
        gen_cfg = value;
        settings_used++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Watchdog: no handshake for too long ends the run
    // ------------------------------------------------------------------
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog expired, %0d rows still owed", $time, expected_rows.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int setting_list[10];
        int idx;
        int base;
        int reps;
        int i;
        int n;

        setting_list = '{16, 7, 1, 31, 0, 12, 3, 20, 5, 9};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset row count of four.
        // Vector extremes, plus a write past the vector that must be ignored.
        push_req(FUNC_LOAD_VEC, 0, 0, 0, 16'h8000);
        push_req(FUNC_LOAD_VEC, 15, 0, 15, 16'h7FFF);
        push_req(FUNC_LOAD_VEC, 255, 256, 15, 16'h1234);
        // Nonzeros at both ends of the store, columns at both ends of the vector.
        push_req(FUNC_LOAD_NZ, 0, 0, 0, 16'h8000);
        push_req(FUNC_LOAD_NZ, 1, 0, 0, 16'h8000);
        push_req(FUNC_LOAD_NZ, 254, 0, 0, 16'h7FFF);
        push_req(FUNC_LOAD_NZ, 255, 256, 15, 16'h8000);
        // Row 0 ends at the top of the nonzero store, row 1 is inverted,
        // row 2 holds the two largest products, row 3 is empty.
        push_req(FUNC_LOAD_PTR, 0, 254, 0, 16'h0000);
        push_req(FUNC_LOAD_PTR, 1, 256, 0, 16'h0000);
        push_req(FUNC_LOAD_PTR, 2, 0, 0, 16'h0000);
        push_req(FUNC_LOAD_PTR, 3, 2, 0, 16'h0000);
        push_req(FUNC_LOAD_PTR, 4, 2, 0, 16'h0000);
        // Row pointer write past the pointer store: ignored.
        push_req(FUNC_LOAD_PTR, MAX_ROWS + 1, 256, 15, 16'hFFFF);
        push_compute();

        // Zero rows: the compute gives no result at all.
        write_rows(0);
        push_compute();

        // Random part: whole vector first, then matrices under changing settings.
        write_rows(setting_list[0]);
        for (i = 0; i < VECTOR_LENGTH; i++)
            push_req(FUNC_LOAD_VEC, i, $urandom_range(0, 256), $urandom_range(0, 15), pick_q88());
        base = gen_items;
        idx = 0;
        while (gen_items - base < RANDOM_ITEMS) begin
            if (idx != 0) write_rows(setting_list[idx % 10]);
            n = (gen_cfg > MAX_ROWS) ? MAX_ROWS : gen_cfg;
            build_matrix(n);
            push_compute();
            reps = $urandom_range(0, 2);
            for (i = 0; i < reps; i++) begin
                tweak_operands();
                push_compute();
            end
            idx++;
        end

        // Final drain: everything owed must arrive, then settle once more.
        drain();
        if (expected_rows.size() != 0) begin
            errors += expected_rows.size();
            $display("%0t: %0d expected rows never arrived", $time, expected_rows.size());
        end

        $display("Covered %0d requests, %0d computes, %0d row results, %0d row-count settings.",
                 accepted, computes_seen, rows_checked, settings_used + 1);
        $display("Included empty, inverted and full-store rows, zero and clamped row counts.");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
